FILE: sv/ple_pkg.sv
// Shared types and constants for the particle lifetime step block.
// Defines the arithmetic unit command word, register indexes and action codes.
// No dependencies.
package ple_pkg;

	typedef enum logic [2:0] {
		UC_HOLD,
		UC_MUL,
		UC_MAC,
		UC_SHADD,
		UC_DIV
	} unit_cmd_t;

	typedef struct packed {
		unit_cmd_t          cmd;
		logic signed [16:0] opa;
		logic signed [16:0] opb;
		logic signed [15:0] addend;
		logic [14:0]        divisor;
	} unit_op_t;

	typedef enum logic [2:0] {
		CFG_START_LIFE,
		CFG_INIT_POSITION,
		CFG_INIT_VELOCITY,
		CFG_ACCELERATION,
		CFG_START_SCALE,
		CFG_END_SCALE,
		CFG_START_COLOR,
		CFG_END_COLOR
	} cfg_reg_t;

	localparam logic ACT_RESTART = 1'b0;
	localparam logic ACT_STEP    = 1'b1;

	localparam logic signed [16:0] ENDLESS_LIFE = -17'sd256;
	localparam logic [14:0]        START_LIFE_RESET = 15'd256;
	localparam int                 CFG_WIDTH = 48;

endpackage

FILE: sv/ple_if.sv
// Request channels of the particle lifetime step block: item in, result out.
// Plain valid/ready handshake. No dependencies.
interface ple_item_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [11:0] elapsed_time;

	modport source (output valid, action, elapsed_time, input ready);
	modport sink (input valid, action, elapsed_time, output ready);
endinterface

interface ple_result_if;
	logic               valid;
	logic               ready;
	logic               alive;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic signed [15:0] pos_z;
	logic [15:0]        scale_x;
	logic [15:0]        scale_y;
	logic [15:0]        scale_z;
	logic [7:0]         color_r;
	logic [7:0]         color_g;
	logic [7:0]         color_b;
	logic [7:0]         color_a;

	modport source (output valid, alive, pos_x, pos_y, pos_z, scale_x, scale_y, scale_z,
		color_r, color_g, color_b, color_a, input ready);
	modport sink (input valid, alive, pos_x, pos_y, pos_z, scale_x, scale_y, scale_z,
		color_r, color_g, color_b, color_a, output ready);
endinterface

FILE: sv/ple_unit.sv
// Shared arithmetic unit: multiply-accumulate, shift-add and one restoring
// divide step per cycle on a single 32-bit accumulator. Depends on ple_pkg.
module ple_unit (
	input  logic               clk,
	input  ple_pkg::unit_op_t  op,
	output logic signed [31:0] acc
);
	import ple_pkg::*;

	logic signed [31:0] acc_q;
	logic signed [31:0] acc_d;
	logic signed [33:0] prod;
	logic signed [31:0] addend_ext;
	logic [31:0]        shifted;
	logic [15:0]        hi;
	logic [15:0]        div_ext;

	assign prod       = op.opa * op.opb;
	assign addend_ext = {{16{op.addend[15]}}, op.addend};
	assign shifted    = {acc_q[30:0], 1'b0};
	assign hi         = shifted[31:16];
	assign div_ext    = {1'b0, op.divisor};

	always_comb begin
		case (op.cmd)
			UC_MUL:   acc_d = prod[31:0] + addend_ext;
			UC_MAC:   acc_d = acc_q + prod[31:0] + addend_ext;
			UC_SHADD: acc_d = (acc_q >>> 8) + addend_ext;
			UC_DIV: begin
				if (hi >= div_ext) acc_d = {hi - div_ext, shifted[15:1], 1'b1};
				else acc_d = shifted;
			end
			default:  acc_d = acc_q;
		endcase
	end

	always_ff @(posedge clk) begin
		acc_q <= acc_d;
	end

	assign acc = acc_q;

endmodule

FILE: sv/particle_lifetime_step.sv
// Top level of the particle lifetime step block: configuration registers,
// particle state, sequencer and result register. Depends on ple_pkg, ple_if
// and ple_unit.
//
// One particle is advanced per step request. A restart request or a step on a dead or
// endless particle goes from acceptance straight to the done state. A step on a live
// particle first runs seven blends on one shared 17x17 multiplier, accumulator and
// restoring divider (two multiply-accumulates, sixteen divide steps, a store each),
// then multiply, add and store for velocity and for position per axis of motion, then
// a life update. The done state loads the result register when free. A new request
// is accepted once the sequencer is idle, even while a result still waits to be taken.
module particle_lifetime_step (
	input  logic                              clk,
	input  logic                              arst_n,
	ple_item_if.sink                          item,
	ple_result_if.source                      result,
	input  logic                              cfg_we,
	input  logic [2:0]                        cfg_index,
	input  logic [ple_pkg::CFG_WIDTH-1:0]     cfg_data
);
	import ple_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BL_MUL,
		ST_BL_MAC,
		ST_BL_DIV,
		ST_BL_STORE,
		ST_MV_MUL,
		ST_MV_ADD,
		ST_MV_STORE,
		ST_MP_MUL,
		ST_MP_ADD,
		ST_MP_STORE,
		ST_LIFE,
		ST_DONE
	} state_t;

	localparam logic [2:0] ELEM_LAST = 3'd6;
	localparam logic [2:0] ELEM_COLOR = 3'd3;
	localparam logic [3:0] DIV_LAST  = 4'd15;
	localparam logic [1:0] AXIS_LAST = 2'd2;

	function automatic logic signed [15:0] sat16(input logic signed [31:0] x);
		if (x > 32'sd32767) return 16'sh7fff;
		else if (x < -32'sd32768) return 16'sh8000;
		else return x[15:0];
	endfunction

	logic [14:0]        start_life_q;
	logic [2:0][15:0]   init_pos_q;
	logic [2:0][15:0]   init_vel_q;
	logic [2:0][15:0]   accel_q;
	logic [2:0][15:0]   start_scale_q;
	logic [2:0][15:0]   end_scale_q;
	logic [3:0][7:0]    start_color_q;
	logic [3:0][7:0]    end_color_q;

	logic signed [16:0] life_q;
	logic signed [15:0] vel_q [3];
	logic signed [15:0] pos_q [3];
	logic [15:0]        scale_q [3];
	logic [7:0]         color_q [4];
	logic               dead_q;

	state_t             state_q;
	logic [2:0]         elem_q;
	logic [3:0]         cnt_q;
	logic [1:0]         axis_q;
	logic [11:0]        dt_q;
	logic [14:0]        lc_q;

	logic               out_valid_q;
	logic               out_alive_q;
	logic signed [15:0] out_pos_q [3];
	logic [15:0]        out_scale_q [3];
	logic [7:0]         out_color_q [4];

	unit_op_t           op;
	logic signed [31:0] acc;
	logic               accept;
	logic               out_load;
	logic [14:0]        lc_d;
	logic [1:0]         cidx;
	logic [15:0]        a_sel;
	logic [15:0]        b_sel;
	logic [15:0]        blend_val;
	logic signed [16:0] life_d;

	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid && item.ready;
	assign out_load   = (state_q == ST_DONE) && (!out_valid_q || result.ready);
	assign cidx       = 2'(elem_q - ELEM_COLOR);
	assign life_d     = life_q - $signed({5'b0, dt_q});

	always_comb begin
		if (life_q[16]) lc_d = '0;
		else if (life_q[15:0] > {1'b0, start_life_q}) lc_d = start_life_q;
		else lc_d = life_q[14:0];
	end

	always_comb begin
		if (elem_q < ELEM_COLOR) begin
			a_sel = start_scale_q[elem_q[1:0]];
			b_sel = end_scale_q[elem_q[1:0]];
		end else begin
			a_sel = {8'b0, start_color_q[cidx]};
			b_sel = {8'b0, end_color_q[cidx]};
		end
		blend_val = (start_life_q == '0) ? b_sel : acc[15:0];
	end

	// drive the shared unit
	always_comb begin
		op.cmd     = UC_HOLD;
		op.opa     = '0;
		op.opb     = '0;
		op.addend  = '0;
		op.divisor = start_life_q;
		case (state_q)
			ST_BL_MUL: begin
				op.cmd = UC_MUL;
				op.opa = $signed({1'b0, a_sel});
				op.opb = $signed({2'b0, lc_q});
			end
			ST_BL_MAC: begin
				op.cmd    = UC_MAC;
				op.opa    = $signed({1'b0, b_sel});
				op.opb    = $signed({2'b0, start_life_q - lc_q});
				op.addend = $signed({2'b0, start_life_q[14:1]});
			end
			ST_BL_DIV: op.cmd = UC_DIV;
			ST_MV_MUL: begin
				op.cmd    = UC_MUL;
				op.opa    = $signed({accel_q[axis_q][15], accel_q[axis_q]});
				op.opb    = $signed({5'b0, dt_q});
				op.addend = 16'sd128;
			end
			ST_MV_ADD: begin
				op.cmd    = UC_SHADD;
				op.addend = vel_q[axis_q];
			end
			ST_MP_MUL: begin
				op.cmd    = UC_MUL;
				op.opa    = {vel_q[axis_q][15], vel_q[axis_q]};
				op.opb    = $signed({5'b0, dt_q});
				op.addend = 16'sd128;
			end
			ST_MP_ADD: begin
				op.cmd    = UC_SHADD;
				op.addend = pos_q[axis_q];
			end
			default: op.cmd = UC_HOLD;
		endcase
	end

	ple_unit u_unit (
		.clk (clk),
		.op  (op),
		.acc (acc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_life_q  <= START_LIFE_RESET;
			init_pos_q    <= '0;
			init_vel_q    <= '0;
			accel_q       <= '0;
			start_scale_q <= '0;
			end_scale_q   <= '0;
			start_color_q <= '0;
			end_color_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START_LIFE:    start_life_q  <= cfg_data[14:0];
				CFG_INIT_POSITION: init_pos_q    <= cfg_data;
				CFG_INIT_VELOCITY: init_vel_q    <= cfg_data;
				CFG_ACCELERATION:  accel_q       <= cfg_data;
				CFG_START_SCALE:   start_scale_q <= cfg_data;
				CFG_END_SCALE:     end_scale_q   <= cfg_data;
				CFG_START_COLOR:   start_color_q <= cfg_data[31:0];
				CFG_END_COLOR:     end_color_q   <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			life_q <= '0;
			dead_q <= 1'b1;
			for (int i = 0; i < 3; i++) begin
				vel_q[i]   <= '0;
				pos_q[i]   <= '0;
				scale_q[i] <= '0;
			end
			for (int i = 0; i < 4; i++) color_q[i] <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && item.action == ACT_RESTART) begin
						life_q <= $signed({2'b0, start_life_q});
						dead_q <= 1'b0;
						for (int i = 0; i < 3; i++) begin
							vel_q[i]   <= init_vel_q[i];
							pos_q[i]   <= init_pos_q[i];
							scale_q[i] <= start_scale_q[i];
						end
						for (int i = 0; i < 4; i++) color_q[i] <= start_color_q[i];
					end
				end
				ST_BL_STORE: begin
					if (elem_q < ELEM_COLOR) scale_q[elem_q[1:0]] <= blend_val;
					else color_q[cidx] <= blend_val[7:0];
				end
				ST_MV_STORE: vel_q[axis_q] <= sat16(acc);
				ST_MP_STORE: pos_q[axis_q] <= sat16(acc);
				ST_LIFE: begin
					life_q <= life_d;
					if (life_d[16]) dead_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			elem_q      <= '0;
			cnt_q       <= '0;
			axis_q      <= '0;
			dt_q        <= '0;
			lc_q        <= '0;
			out_valid_q <= 1'b0;
			out_alive_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				out_pos_q[i]   <= '0;
				out_scale_q[i] <= '0;
			end
			for (int i = 0; i < 4; i++) out_color_q[i] <= '0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (result.valid && result.ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						dt_q   <= item.elapsed_time;
						lc_q   <= lc_d;
						elem_q <= '0;
						axis_q <= '0;
						if (item.action == ACT_RESTART || dead_q || life_q <= ENDLESS_LIFE)
							state_q <= ST_DONE;
						else
							state_q <= ST_BL_MUL;
					end
				end
				ST_BL_MUL: state_q <= ST_BL_MAC;
				ST_BL_MAC: begin
					cnt_q   <= '0;
					state_q <= ST_BL_DIV;
				end
				ST_BL_DIV: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == DIV_LAST) state_q <= ST_BL_STORE;
				end
				ST_BL_STORE: begin
					if (elem_q == ELEM_LAST) begin
						state_q <= ST_MV_MUL;
					end else begin
						elem_q  <= elem_q + 3'd1;
						state_q <= ST_BL_MUL;
					end
				end
				ST_MV_MUL:   state_q <= ST_MV_ADD;
				ST_MV_ADD:   state_q <= ST_MV_STORE;
				ST_MV_STORE: state_q <= ST_MP_MUL;
				ST_MP_MUL:   state_q <= ST_MP_ADD;
				ST_MP_ADD:   state_q <= ST_MP_STORE;
				ST_MP_STORE: begin
					if (axis_q == AXIS_LAST) begin
						state_q <= ST_LIFE;
					end else begin
						axis_q  <= axis_q + 2'd1;
						state_q <= ST_MV_MUL;
					end
				end
				ST_LIFE: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_load) begin
						out_alive_q <= !dead_q;
						for (int i = 0; i < 3; i++) begin
							out_pos_q[i]   <= pos_q[i];
							out_scale_q[i] <= scale_q[i];
						end
						for (int i = 0; i < 4; i++) out_color_q[i] <= color_q[i];
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result.valid   = out_valid_q;
	assign result.alive   = out_alive_q;
	assign result.pos_x   = out_pos_q[0];
	assign result.pos_y   = out_pos_q[1];
	assign result.pos_z   = out_pos_q[2];
	assign result.scale_x = out_scale_q[0];
	assign result.scale_y = out_scale_q[1];
	assign result.scale_z = out_scale_q[2];
	assign result.color_r = out_color_q[0];
	assign result.color_g = out_color_q[1];
	assign result.color_b = out_color_q[2];
	assign result.color_a = out_color_q[3];

endmodule

FILE: tb/testbench.sv
// Testbench for particle_lifetime_step: drives restart and step requests with random gaps,
// predicts each result from its own copy of the particle state and registers, and checks it.
// Depends on ple_pkg, ple_if and particle_lifetime_step.
module testbench;
	import ple_pkg::*;

	typedef struct packed {
		logic        action;
		logic [11:0] dt;
	} step_req_t;

	typedef struct packed {
		logic        alive;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [15:0] pos_z;
		logic [15:0] scale_x;
		logic [15:0] scale_y;
		logic [15:0] scale_z;
		logic [7:0]  color_r;
		logic [7:0]  color_g;
		logic [7:0]  color_b;
		logic [7:0]  color_a;
	} particle_view_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	cfg_reg_t             cfg_index;
	logic [CFG_WIDTH-1:0] cfg_data;

	ple_item_if   item_ch();
	ple_result_if result_ch();

	particle_lifetime_step uut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// register copies
	logic [14:0] start_life;
	logic [47:0] init_pos, init_vel, accel, start_scale, end_scale;
	logic [31:0] start_color, end_color;

	// particle state
	logic signed [16:0] life_left;
	logic signed [15:0] vel_now [3];
	logic signed [15:0] pos_now [3];
	logic [15:0]        scale_now [3];
	logic [7:0]         color_now [4];
	logic               dead;

	step_req_t      requests_waiting [$];
	particle_view_t due_views [$];
	step_req_t      next_req;
	particle_view_t want;
	logic           item_taken;
	int             requests_queued;
	int             requests_taken;
	int             views_checked;
	int             mismatches;
	int             settings_used;
	int unsigned    send_idle_pct;
	int unsigned    stall_pct;

	function automatic longint round_q8(longint p);
		return (p + 128) >>> 8;
	endfunction

	function automatic logic signed [15:0] clamp16(longint v);
		if (v > 32767)
			return 16'sh7FFF;
		if (v < -32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic logic [15:0] mix_by_life(logic [15:0] a, logic [15:0] b,
			int unsigned l, int unsigned span);
		longint unsigned num;
		if (span == 0)
			return b;
		num = longint'(a) * l + longint'(b) * (span - l) + span / 2;
		return 16'(num / span);
	endfunction

	function automatic particle_view_t advance_particle(logic act, logic [11:0] dt);
		particle_view_t view;
		int unsigned    span, lc;
		longint         acc, dtl;
		int             i;
		dtl = dt;
		if (act == ACT_RESTART) begin
			life_left = $signed({2'b00, start_life});
			for (i = 0; i < 3; i++) begin
				pos_now[i] = init_pos[16*i +: 16];
				vel_now[i] = init_vel[16*i +: 16];
				scale_now[i] = start_scale[16*i +: 16];
			end
			for (i = 0; i < 4; i++)
				color_now[i] = start_color[8*i +: 8];
			dead = 1'b0;
		end else if (!dead && life_left > ENDLESS_LIFE) begin
			span = 32'(start_life);
			lc = (life_left < 0) ? 0 : int'(life_left);
			if (lc > span)
				lc = span;
			for (i = 0; i < 3; i++)
				scale_now[i] = mix_by_life(start_scale[16*i +: 16], end_scale[16*i +: 16],
					lc, span);
			for (i = 0; i < 4; i++)
				color_now[i] = 8'(mix_by_life({8'h00, start_color[8*i +: 8]},
					{8'h00, end_color[8*i +: 8]}, lc, span));
			for (i = 0; i < 3; i++) begin
				acc = longint'($signed(accel[16*i +: 16]));
				vel_now[i] = clamp16(longint'(vel_now[i]) + round_q8(acc * dtl));
				pos_now[i] = clamp16(longint'(pos_now[i]) + round_q8(longint'(vel_now[i]) * dtl));
			end
			life_left = life_left - $signed({5'b00000, dt});
			if (life_left < 0)
				dead = 1'b1;
		end
		view.alive = !dead;
		view.pos_x = pos_now[0];
		view.pos_y = pos_now[1];
		view.pos_z = pos_now[2];
		view.scale_x = scale_now[0];
		view.scale_y = scale_now[1];
		view.scale_z = scale_now[2];
		view.color_r = color_now[0];
		view.color_g = color_now[1];
		view.color_b = color_now[2];
		view.color_a = color_now[3];
		return view;
	endfunction

	function automatic void compare_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
		if (exp_v !== got_v) begin
			mismatches++;
			$display("%0t %s: expected %h, got %h", $time, name, exp_v, got_v);
		end
	endfunction

	task automatic queue_request(input logic act, input logic [11:0] dt);
		step_req_t req;
		req.action = act;
		req.dt = dt;
		requests_waiting.push_back(req);
		requests_queued++;
	endtask

	task automatic drain();
		do
			@(negedge clk);
		while (requests_taken != requests_queued || due_views.size() != 0);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [47:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			CFG_START_LIFE:    start_life = value[14:0];
			CFG_INIT_POSITION: init_pos = value;
			CFG_INIT_VELOCITY: init_vel = value;
			CFG_ACCELERATION:  accel = value;
			CFG_START_SCALE:   start_scale = value;
			CFG_END_SCALE:     end_scale = value;
			CFG_START_COLOR:   start_color = value[31:0];
			CFG_END_COLOR:     end_color = value[31:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [15:0] rand_lane();
		logic [15:0] v;
		case ($urandom_range(9))
			0: v = 16'h7FFF;
			1: v = 16'h8000;
			2, 3, 4: v = 16'($urandom);
			default: begin
				v = 16'($urandom_range(1023));
				v = v - 16'd512;
			end
		endcase
		return v;
	endfunction

	function automatic logic [31:0] rand_color();
		case ($urandom_range(5))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic randomize_settings();
		int unsigned pick;
		logic [14:0] life;
		pick = $urandom_range(9);
		case (pick)
			0: life = 15'd0;
			1: life = 15'd1;
			2: life = 15'h7FFF;
			3, 4, 5: life = 15'($urandom_range(1, 2000));
			default: life = 15'($urandom_range(1, 32767));
		endcase
		write_reg(CFG_START_LIFE, {33'd0, life});
		write_reg(CFG_INIT_POSITION, {rand_lane(), rand_lane(), rand_lane()});
		write_reg(CFG_INIT_VELOCITY, {rand_lane(), rand_lane(), rand_lane()});
		write_reg(CFG_ACCELERATION, {rand_lane(), rand_lane(), rand_lane()});
		write_reg(CFG_START_SCALE, {rand_lane(), rand_lane(), rand_lane()});
		write_reg(CFG_END_SCALE, {rand_lane(), rand_lane(), rand_lane()});
		write_reg(CFG_START_COLOR, {16'd0, rand_color()});
		write_reg(CFG_END_COLOR, {16'd0, rand_color()});
		settings_used++;
	endtask

	task automatic queue_random_block(input int count);
		int lim, n, r;
		lim = start_life / 6 + 1;
		if (lim > 4095)
			lim = 4095;
		@(posedge clk);
		if ($urandom_range(3) != 0)
			queue_request(ACT_RESTART, 12'($urandom_range(4095)));
		for (n = 0; n < count; n++) begin
			r = $urandom_range(99);
			if (r < 8)
				queue_request(ACT_RESTART, 12'($urandom_range(4095)));
			else if (r < 72)
				queue_request(ACT_STEP, 12'($urandom_range(lim)));
			else if (r < 88)
				queue_request(ACT_STEP, 12'($urandom_range(4095)));
			else
				queue_request(ACT_STEP, 12'd0);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#30_000_000;
		$display("tb: failure");
		$finish;
	end

	// request driver and result backpressure
	always @(negedge clk) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= $urandom_range(99) >= stall_pct;
			if (!item_ch.valid || item_taken) begin
				if (requests_waiting.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_req = requests_waiting.pop_front();
					item_ch.valid <= 1'b1;
					item_ch.action <= next_req.action;
					item_ch.elapsed_time <= next_req.dt;
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result checker and request predictor
	always @(posedge clk) begin
		item_taken <= arst_n && item_ch.valid && item_ch.ready;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			views_checked++;
			if (due_views.size() == 0) begin
				mismatches++;
				$display("%0t unexpected result: expected none, got %h", $time,
					{result_ch.alive, result_ch.pos_x, result_ch.pos_y, result_ch.pos_z});
			end else begin
				want = due_views.pop_front();
				compare_field("alive", want.alive, result_ch.alive);
				compare_field("pos_x", want.pos_x, result_ch.pos_x);
				compare_field("pos_y", want.pos_y, result_ch.pos_y);
				compare_field("pos_z", want.pos_z, result_ch.pos_z);
				compare_field("scale_x", want.scale_x, result_ch.scale_x);
				compare_field("scale_y", want.scale_y, result_ch.scale_y);
				compare_field("scale_z", want.scale_z, result_ch.scale_z);
				compare_field("color_r", want.color_r, result_ch.color_r);
				compare_field("color_g", want.color_g, result_ch.color_g);
				compare_field("color_b", want.color_b, result_ch.color_b);
				compare_field("color_a", want.color_a, result_ch.color_a);
			end
		end
		if (arst_n && item_ch.valid && item_ch.ready) begin
			due_views.push_back(advance_particle(item_ch.action, item_ch.elapsed_time));
			requests_taken++;
		end
	end

	initial begin
		int          ph, blk, n;
		int unsigned send_pct [4];
		int unsigned hold_pct [4];
		send_pct = '{0, 78, 0, 20};
		hold_pct = '{0, 0, 78, 20};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_START_LIFE;
		cfg_data = '0;
		item_ch.valid = 1'b0;
		item_ch.action = ACT_RESTART;
		item_ch.elapsed_time = '0;
		result_ch.ready = 1'b0;
		item_taken = 1'b0;
		requests_queued = 0;
		requests_taken = 0;
		views_checked = 0;
		mismatches = 0;
		settings_used = 1;
		send_idle_pct = 0;
		stall_pct = 0;
		start_life = START_LIFE_RESET;
		init_pos = '0;
		init_vel = '0;
		accel = '0;
		start_scale = '0;
		end_scale = '0;
		start_color = '0;
		end_color = '0;
		life_left = '0;
		for (n = 0; n < 3; n++) begin
			vel_now[n] = '0;
			pos_now[n] = '0;
			scale_now[n] = '0;
		end
		for (n = 0; n < 4; n++)
			color_now[n] = '0;
		dead = 1'b1;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// step before any restart, then a short life that expires
		@(posedge clk);
		queue_request(ACT_STEP, 12'd5);
		queue_request(ACT_RESTART, 12'd0);
		queue_request(ACT_STEP, 12'd0);
		queue_request(ACT_STEP, 12'd300);
		queue_request(ACT_STEP, 12'd1);
		queue_request(ACT_STEP, 12'hFFF);
		drain();

		// extreme registers: saturating motion and a full-length life
		write_reg(CFG_START_LIFE, 48'h7FFF);
		write_reg(CFG_INIT_POSITION, {16'h0000, 16'h7FFF, 16'h8000});
		write_reg(CFG_INIT_VELOCITY, {16'h0100, 16'h8000, 16'h7FFF});
		write_reg(CFG_ACCELERATION, {16'hFFFF, 16'h8000, 16'h7FFF});
		write_reg(CFG_START_SCALE, 48'h0000_0000_0000);
		write_reg(CFG_END_SCALE, 48'hFFFF_FFFF_FFFF);
		write_reg(CFG_START_COLOR, 48'h00FF_00FF);
		write_reg(CFG_END_COLOR, 48'hFF00_FF00);
		settings_used++;
		@(posedge clk);
		queue_request(ACT_RESTART, 12'hFFF);
		for (n = 0; n < 8; n++)
			queue_request(ACT_STEP, 12'hFFF);
		queue_request(ACT_STEP, 12'd7);
		queue_request(ACT_STEP, 12'd0);
		queue_request(ACT_STEP, 12'd1);
		drain();

		// zero life span: end values at once
		write_reg(CFG_START_LIFE, 48'h0);
		settings_used++;
		@(posedge clk);
		queue_request(ACT_RESTART, 12'd0);
		queue_request(ACT_STEP, 12'd0);
		queue_request(ACT_STEP, 12'd1);
		drain();

		// life above the span after the span shrinks
		write_reg(CFG_START_LIFE, 48'd1000);
		@(posedge clk);
		queue_request(ACT_RESTART, 12'd0);
		drain();
		write_reg(CFG_START_LIFE, 48'd10);
		settings_used += 2;
		@(posedge clk);
		queue_request(ACT_STEP, 12'd1);
		queue_request(ACT_STEP, 12'hFFF);

		for (ph = 0; ph < 4; ph++) begin
			for (blk = 0; blk < 4; blk++) begin
				drain();
				randomize_settings();
				send_idle_pct = send_pct[ph];
				stall_pct = hold_pct[ph];
				queue_random_block(25);
			end
		end

		drain();
		repeat (200) @(negedge clk);
		$display("covered %0d requests and %0d results over %0d register settings",
			requests_taken, views_checked, settings_used);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
